[hw/rtl/disjoint_range_merge_table_assert.svh]
// assertion macros for the range table checker
`ifndef DISJOINT_RANGE_MERGE_TABLE_ASSERT_SVH
`define DISJOINT_RANGE_MERGE_TABLE_ASSERT_SVH

// clocked assertion, off while reset is low
`define DRMT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("range table assertion failed");

// same, for a check with a separate antecedent and a non-overlapping consequent
`define DRMT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("range table assertion failed");

`endif

[hw/rtl/drmt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package drmt_pkg;

  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned MAX_RANGES  = 32;
  localparam int unsigned CNT_W       = $clog2(MAX_RANGES + 1);
  localparam int unsigned ADDR_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned WORD_W      = 2 * VALUE_WIDTH;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_LIST = 1'b1
  } drmt_op_e;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_MERGED  = 3'd1,
    ST_COVERED = 3'd2,
    ST_FULL    = 3'd3,
    ST_ENTRY   = 3'd4,
    ST_EMPTY   = 3'd5
  } drmt_status_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_CLR,
    PTR_INC,
    PTR_DEC,
    PTR_CNT
  } drmt_ptr_op_e;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_P1,
    RD_PTR_M1
  } drmt_rd_sel_e;

  typedef enum logic {
    WA_PTR,
    WA_PTR_M1
  } drmt_wa_sel_e;

  typedef enum logic [2:0] {
    WD_BRIDGE,
    WD_LEFT,
    WD_RIGHT,
    WD_SINGLE,
    WD_RDATA
  } drmt_wd_sel_e;

  typedef enum logic [1:0] {
    EM_DECIDE,
    EM_ENTRY,
    EM_EMPTY
  } drmt_em_sel_e;

  typedef struct packed {
    logic         in_ready;
    logic         load_in;
    drmt_ptr_op_e ptr_op;
    logic         rd_en;
    drmt_rd_sel_e rd_sel;
    logic         wr_en;
    drmt_wa_sel_e wa_sel;
    drmt_wd_sel_e wd_sel;
    logic         save_prev;
    logic         save_next;
    logic         save_idx;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         emit;
    drmt_em_sel_e em_sel;
  } drmt_cmd_t;

  typedef struct packed {
    logic     in_valid;
    drmt_op_e in_op;
    logic     ptr_eq_cnt;
    logic     ptr_eq_idx;
    logic     p1_ge_cnt;
    logic     last_entry;
    logic     cnt_zero;
    logic     start_le_v;
    logic     covered;
    logic     join_left;
    logic     join_right;
    logic     full;
    logic     slot_free;
  } drmt_stat_t;

endpackage
`default_nettype wire

[hw/rtl/drmt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface drmt_in_if import drmt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface drmt_out_if import drmt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic [VALUE_WIDTH-1:0] range_low;
  logic [VALUE_WIDTH-1:0] range_high;
  logic                   last;

  modport source (output valid, output status, output range_low, output range_high,
                  output last, input ready);
  modport sink (input valid, input status, input range_low, input range_high,
                input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/drmt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module drmt_ctrl import drmt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  drmt_stat_t stat_i,
  output drmt_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CK,
    S_DECIDE,
    S_SHDN_RD,
    S_SHDN_WR,
    S_SHUP_RD,
    S_SHUP_WR,
    S_LIST_RD,
    S_LIST_EM
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    cmd_o.ptr_op = PTR_HOLD;
    cmd_o.rd_sel = RD_PTR;
    cmd_o.wa_sel = WA_PTR;
    cmd_o.wd_sel = WD_RDATA;
    cmd_o.em_sel = EM_DECIDE;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.load_in = 1'b1;
          cmd_o.ptr_op  = PTR_CLR;
          state_d = (stat_i.in_op == OP_LIST) ? S_LIST_RD : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat_i.ptr_eq_cnt) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (stat_i.start_le_v) begin
          cmd_o.save_prev = 1'b1;
          cmd_o.ptr_op    = PTR_INC;
          state_d = S_SCAN_RD;
        end else begin
          cmd_o.save_next = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.slot_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.em_sel = EM_DECIDE;
          if (stat_i.covered) begin
            state_d = S_IDLE;
          end else if (stat_i.join_left && stat_i.join_right) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wa_sel = WA_PTR_M1;
            cmd_o.wd_sel = WD_BRIDGE;
            state_d = S_SHDN_RD;
          end else if (stat_i.join_left) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wa_sel = WA_PTR_M1;
            cmd_o.wd_sel = WD_LEFT;
            state_d = S_IDLE;
          end else if (stat_i.join_right) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wd_sel = WD_RIGHT;
            state_d = S_IDLE;
          end else if (stat_i.full) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.save_idx = 1'b1;
            cmd_o.ptr_op   = PTR_CNT;
            state_d = S_SHUP_RD;
          end
        end
      end
      S_SHDN_RD: begin
        if (stat_i.p1_ge_cnt) begin
          cmd_o.cnt_dec = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR_P1;
          state_d = S_SHDN_WR;
        end
      end
      S_SHDN_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.ptr_op = PTR_INC;
        state_d = S_SHDN_RD;
      end
      S_SHUP_RD: begin
        if (stat_i.ptr_eq_idx) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wd_sel  = WD_SINGLE;
          cmd_o.cnt_inc = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR_M1;
          state_d = S_SHUP_WR;
        end
      end
      S_SHUP_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.ptr_op = PTR_DEC;
        state_d = S_SHUP_RD;
      end
      S_LIST_RD: begin
        if (stat_i.cnt_zero) begin
          if (stat_i.slot_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.em_sel = EM_EMPTY;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = S_LIST_EM;
        end
      end
      S_LIST_EM: begin
        if (stat_i.slot_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.em_sel = EM_ENTRY;
          cmd_o.ptr_op = PTR_INC;
          state_d = stat_i.last_entry ? S_IDLE : S_LIST_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/drmt_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
module drmt_dpath import drmt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  drmt_cmd_t  cmd_i,
  output drmt_stat_t stat_o,
  drmt_in_if.sink    req_i,
  drmt_out_if.source rsp_o
);

  logic [WORD_W-1:0]      mem_q [MAX_RANGES];
  logic [WORD_W-1:0]      rdata_q;
  logic [CNT_W-1:0]       cnt_q, ptr_q, idx_q;
  logic [CNT_W-1:0]       ptr_p1, ptr_m1;
  logic [VALUE_WIDTH-1:0] v_q, prev_s_q, prev_e_q, next_s_q, next_e_q;
  logic [ADDR_W-1:0]      rd_addr, wr_addr;
  logic [WORD_W-1:0]      wr_data;
  logic                   has_prev, has_next;
  logic [VALUE_WIDTH:0]   v_p1, prev_e_p1;

  logic                   out_valid_q;
  drmt_status_e           out_status_q, em_status;
  logic [VALUE_WIDTH-1:0] out_low_q, out_high_q, em_low, em_high;
  logic                   out_last_q, em_last;

  assign ptr_p1    = ptr_q + 1'b1;
  assign ptr_m1    = ptr_q - 1'b1;
  assign has_prev  = (ptr_q != '0);
  assign has_next  = (ptr_q != cnt_q);
  assign v_p1      = {1'b0, v_q} + 1'b1;
  assign prev_e_p1 = {1'b0, prev_e_q} + 1'b1;

  assign req_i.ready = cmd_i.in_ready;

  always_comb begin
    stat_o            = '0;
    stat_o.in_valid   = req_i.valid;
    stat_o.in_op      = drmt_op_e'(req_i.opcode);
    stat_o.ptr_eq_cnt = (ptr_q == cnt_q);
    stat_o.ptr_eq_idx = (ptr_q == idx_q);
    stat_o.p1_ge_cnt  = (ptr_p1 >= cnt_q);
    stat_o.last_entry = (ptr_p1 == cnt_q);
    stat_o.cnt_zero   = (cnt_q == '0);
    stat_o.start_le_v = (rdata_q[WORD_W-1:VALUE_WIDTH] <= v_q);
    stat_o.covered    = has_prev && (prev_e_q >= v_q);
    stat_o.join_left  = has_prev && (prev_e_p1 == {1'b0, v_q});
    stat_o.join_right = has_next && (v_p1 == {1'b0, next_s_q});
    stat_o.full       = (cnt_q == CNT_W'(MAX_RANGES));
    stat_o.slot_free  = !out_valid_q || rsp_o.ready;
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PTR_P1: rd_addr = ptr_p1[ADDR_W-1:0];
      RD_PTR_M1: rd_addr = ptr_m1[ADDR_W-1:0];
      default:   rd_addr = ptr_q[ADDR_W-1:0];
    endcase
    case (cmd_i.wa_sel)
      WA_PTR_M1: wr_addr = ptr_m1[ADDR_W-1:0];
      default:   wr_addr = ptr_q[ADDR_W-1:0];
    endcase
    case (cmd_i.wd_sel)
      WD_BRIDGE: wr_data = {prev_s_q, next_e_q};
      WD_LEFT:   wr_data = {prev_s_q, v_q};
      WD_RIGHT:  wr_data = {v_q, next_e_q};
      WD_SINGLE: wr_data = {v_q, v_q};
      default:   wr_data = rdata_q;
    endcase
  end

  // table storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      v_q <= req_i.value;
    end
    if (cmd_i.save_prev) begin
      prev_s_q <= rdata_q[WORD_W-1:VALUE_WIDTH];
      prev_e_q <= rdata_q[VALUE_WIDTH-1:0];
    end
    if (cmd_i.save_next) begin
      next_s_q <= rdata_q[WORD_W-1:VALUE_WIDTH];
      next_e_q <= rdata_q[VALUE_WIDTH-1:0];
    end
    if (cmd_i.save_idx) begin
      idx_q <= ptr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else begin
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - 1'b1;
      end
      case (cmd_i.ptr_op)
        PTR_CLR: ptr_q <= '0;
        PTR_INC: ptr_q <= ptr_p1;
        PTR_DEC: ptr_q <= ptr_m1;
        PTR_CNT: ptr_q <= cnt_q;
        default: ptr_q <= ptr_q;
      endcase
    end
  end

  // result of an add, or one listing step
  always_comb begin
    em_last = 1'b1;
    em_low  = v_q;
    em_high = v_q;
    case (cmd_i.em_sel)
      EM_ENTRY: begin
        em_status = ST_ENTRY;
        em_low    = rdata_q[WORD_W-1:VALUE_WIDTH];
        em_high   = rdata_q[VALUE_WIDTH-1:0];
        em_last   = stat_o.last_entry;
      end
      EM_EMPTY: begin
        em_status = ST_EMPTY;
        em_low    = '0;
        em_high   = '0;
      end
      default: begin
        if (stat_o.covered) begin
          em_status = ST_COVERED;
          em_low    = prev_s_q;
          em_high   = prev_e_q;
        end else if (stat_o.join_left && stat_o.join_right) begin
          em_status = ST_MERGED;
          em_low    = prev_s_q;
          em_high   = next_e_q;
        end else if (stat_o.join_left) begin
          em_status = ST_MERGED;
          em_low    = prev_s_q;
        end else if (stat_o.join_right) begin
          em_status = ST_MERGED;
          em_high   = next_e_q;
        end else if (stat_o.full) begin
          em_status = ST_FULL;
        end else begin
          em_status = ST_NEW;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= em_status;
      out_low_q    <= em_low;
      out_high_q   <= em_high;
      out_last_q   <= em_last;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.range_low  = out_low_q;
  assign rsp_o.range_high = out_high_q;
  assign rsp_o.last       = out_last_q;

endmodule
`default_nettype wire

[hw/rtl/disjoint_range_merge_table.sv]
// channel   dir  payload                               handshake
// req_i     in   opcode, value                         valid / ready
// rsp_o     out  status, range_low, range_high, last   valid / ready
//
// add: a read and a check per stored range below the value, a decide step, then a read
//   and a write per entry moved when a range opens or two ranges join
// list: a read and an emit per stored range, as the table has a single read port
// one request in flight; the next is taken once the sequence is back in idle
// reset clears the range count, pointer, output valid and state; table contents need no clearing
// a stalled rsp_o holds the pending result and pauses the sequence
`timescale 1ns / 1ps
`default_nettype none
module disjoint_range_merge_table import drmt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  drmt_in_if.sink    req_i,
  drmt_out_if.source rsp_o
);

  drmt_cmd_t  cmd;
  drmt_stat_t stat;

  drmt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  drmt_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule
`default_nettype wire

[hw/rtl/drmt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "disjoint_range_merge_table_assert.svh"
module drmt_checker import drmt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [2:0] rsp_status_i,
  input logic       rsp_last_i
);

  `DRMT_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
  `DRMT_ASSERT_NEXT(a_busy_after_req, req_valid_i && req_ready_i, !req_ready_i)
  `DRMT_ASSERT(a_single_last, rsp_valid_i && (rsp_status_i != ST_ENTRY) |-> rsp_last_i)
  `DRMT_ASSERT(a_no_req_while_out, rsp_valid_i && !rsp_ready_i && !rsp_last_i |-> !req_ready_i)

endmodule

bind disjoint_range_merge_table drmt_checker u_drmt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_last_i   (rsp_o.last)
);
`default_nettype wire
